// ===== hw/rtl/itda_pkg.sv =====
// itda_pkg: shared types and constants for the binary to decimal ascii converter
// no dependencies; imported by itda_dabble and int_to_decimal_ascii
package itda_pkg;

  // widths of the number and of its decimal form
  localparam int MAG_W  = 32;
  localparam int NIB_W  = 4;
  localparam int DIGITS = 10;
  localparam int BCD_W  = DIGITS * NIB_W;
  localparam int CHAR_W = 7;

  // bit step counter and digit counter widths
  localparam int CNT_W = $clog2(MAG_W);
  localparam int REM_W = $clog2(DIGITS + 1);

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // func codes
  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

  // input beat: one number
  typedef struct packed {
    logic             func;
    logic [MAG_W-1:0] value;
  } num_beat_t;

  // output beat: one character
  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } chr_beat_t;

endpackage

// ===== hw/rtl/int_to_decimal_ascii.sv =====
// int_to_decimal_ascii: 32-bit number to decimal ascii character stream
// depends on itda_pkg and itda_dabble
//
// Usage: one number beat (func, value) enters on num_valid/num_ready; its
// decimal form leaves as character beats on chr_valid/chr_ready, most
// significant digit first, leading zeros dropped, last set on the final
// character. With func set and bit 31 high a '-' comes first, followed by
// the magnitude (two's complement negation, so -2147483648 is exact).
// A number goes through the shift and add-3 unit (one bit a cycle); its
// digits are then taken, the skip step drops each leading zero digit,
// and the emit step sends one digit per character beat. The '-' goes
// out as soon as the output register is free, so with chr_ready high
// it leaves while the conversion runs.
// num_ready is high only while the block is idle; the final character
// may still wait in the output register when the next number is taken.
// A stalled receiver holds the output register and the emit step only.
// Reset (rst, synchronous) returns to idle and drops any pending beat.
module int_to_decimal_ascii (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 num_valid,
  output logic                 num_ready,
  input  itda_pkg::num_beat_t  num,
  output logic                 chr_valid,
  input  logic                 chr_ready,
  output itda_pkg::chr_beat_t  chr
);
  import itda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             sign_pend;
  logic [BCD_W-1:0] dig;
  logic [REM_W-1:0] rem;
  logic             num_acc;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic             dab_done;
  logic [BCD_W-1:0] dab_bcd;
  logic             slot_free;
  logic             load_minus;
  logic             load_digit;
  logic             skip_zero;
  logic [NIB_W-1:0] top_digit;

  // input side: sign and magnitude
  assign num_ready = (state == S_IDLE);
  assign num_acc   = num_valid && num_ready;
  assign neg       = (num.func == FUNC_SIGNED) && num.value[MAG_W-1];
  assign mag       = neg ? (~num.value + MAG_W'(1)) : num.value;

  itda_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (num_acc),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  // output register loads
  assign top_digit  = dig[BCD_W-1 -: NIB_W];
  assign slot_free  = !chr_valid || chr_ready;
  assign load_minus = sign_pend && slot_free && (state != S_IDLE);
  assign load_digit = (state == S_EMIT) && !sign_pend && slot_free;
  assign skip_zero  = (top_digit == '0) && (rem != REM_W'(1));

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (num_acc) state_next = S_CONV;
      S_CONV: if (dab_done) state_next = S_SKIP;
      S_SKIP: if (!skip_zero) state_next = S_EMIT;
      S_EMIT: if (load_digit && (rem == REM_W'(1))) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
      chr_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (num_acc) begin
        sign_pend <= neg;
      end else if (load_minus) begin
        sign_pend <= 1'b0;
      end
      if (load_minus || load_digit) begin
        chr_valid <= 1'b1;
      end else if (chr_ready) begin
        chr_valid <= 1'b0;
      end
    end
  end

  // digit shifter: drop leading zeros, then feed characters out
  always_ff @(posedge clk) begin
    if (state == S_CONV && dab_done) begin
      dig <= dab_bcd;
      rem <= REM_W'(DIGITS);
    end else if ((state == S_SKIP && skip_zero) || load_digit) begin
      dig <= {dig[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
      rem <= rem - REM_W'(1);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_minus) begin
      chr.ascii_char <= CHAR_MINUS;
      chr.last       <= 1'b0;
    end else if (load_digit) begin
      chr.ascii_char <= CHAR_ZERO + {{(CHAR_W-NIB_W){1'b0}}, top_digit};
      chr.last       <= (rem == REM_W'(1));
    end
  end

endmodule

// ===== hw/rtl/itda_dabble.sv =====
// itda_dabble: iterative shift and add-3 binary to bcd converter, one bit per cycle
// depends on itda_pkg
module itda_dabble (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [itda_pkg::MAG_W-1:0]  mag,
  output logic                        done,
  output logic [itda_pkg::BCD_W-1:0]  bcd
);
  import itda_pkg::*;

  logic [MAG_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [BCD_W-1:0] bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*NIB_W +: NIB_W] >= NIB_W'(5)) begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W] + NIB_W'(3);
      end else begin
        bcd_adj[i*NIB_W +: NIB_W] = bcd[i*NIB_W +: NIB_W];
      end
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNT_W'(MAG_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MAG_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath: shift one binary bit into the bcd word each step
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag;
      bcd   <= '0;
    end else if (run) begin
      shreg <= {shreg[MAG_W-2:0], 1'b0};
      bcd   <= {bcd_adj[BCD_W-2:0], shreg[MAG_W-1]};
    end
  end

endmodule
